[src/ifp_pkg.sv]
// package for the infix to postfix converter: token codes, status codes, priorities, states
`default_nettype none

package ifp_pkg;

    localparam int KIND_W = 3;
    localparam int OP_W   = 4;
    localparam int STAT_W = 2;
    localparam int PRIO_W = 6;

    // token kinds
    localparam logic [KIND_W-1:0] K_OPERAND      = 3'd0;
    localparam logic [KIND_W-1:0] K_OPEN_PAREN   = 3'd1;
    localparam logic [KIND_W-1:0] K_CLOSE_PAREN  = 3'd2;
    localparam logic [KIND_W-1:0] K_OPEN_SQUARE  = 3'd3;
    localparam logic [KIND_W-1:0] K_CLOSE_SQUARE = 3'd4;
    localparam logic [KIND_W-1:0] K_OPERATOR     = 3'd5;
    localparam logic [KIND_W-1:0] K_ARRAY        = 3'd6;
    localparam logic [KIND_W-1:0] K_FUNCTION     = 3'd7;

    // operator codes
    localparam logic [OP_W-1:0] OP_ADD  = 4'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 4'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 4'd3;
    localparam logic [OP_W-1:0] OP_POW  = 4'd4;
    localparam logic [OP_W-1:0] OP_NEG  = 4'd5;
    localparam logic [OP_W-1:0] OP_FACT = 4'd6;
    localparam logic [OP_W-1:0] OP_MOD  = 4'd7;
    localparam logic [OP_W-1:0] OP_AND  = 4'd8;
    localparam logic [OP_W-1:0] OP_OR   = 4'd9;
    localparam logic [OP_W-1:0] OP_NOT  = 4'd10;
    localparam logic [OP_W-1:0] OP_NONE = 4'd0;

    // result status
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_OPENER = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;

    // priorities
    localparam logic [PRIO_W-1:0] PRIO_LOGIC = 6'd5;
    localparam logic [PRIO_W-1:0] PRIO_ADD   = 6'd10;
    localparam logic [PRIO_W-1:0] PRIO_MUL   = 6'd20;
    localparam logic [PRIO_W-1:0] PRIO_POW   = 6'd30;
    localparam logic [PRIO_W-1:0] PRIO_NOT   = 6'd40;
    localparam logic [PRIO_W-1:0] PRIO_NONE  = 6'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_END,
        S_DONE
    } t_state;

    function automatic logic [PRIO_W-1:0] f_prio(input logic [OP_W-1:0] op);
        logic [PRIO_W-1:0] p;
        case (op)
            OP_ADD, OP_SUB, OP_NEG:  p = PRIO_ADD;
            OP_MUL, OP_DIV, OP_MOD:  p = PRIO_MUL;
            OP_POW, OP_FACT:         p = PRIO_POW;
            OP_AND, OP_OR:           p = PRIO_LOGIC;
            OP_NOT:                  p = PRIO_NOT;
            default:                 p = PRIO_NONE;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[src/ifp_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module ifp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[src/infix_to_postfix_converter.sv]
// top level of the infix to postfix converter: sequencer, operator stack and output stage
`default_nettype none

// Shunting-yard converter. Classified tokens come in on the slave stream and leave in postfix
// order on the master stream. The operator stack lives in a one-port-read ram with registered
// read data, so every pop passes through S_READ, which reads the top, and S_EVAL, which judges
// and emits it. An opening bracket that fits is pushed at once; an operator, array or function
// name first pops what it displaces and is then pushed, or answered with an overflow word when
// the stack is full. A closing bracket pops down to its opener and drops it, and a flush
// empties the stack and ends with an end marker; a stalled master side holds the sequencer.
// Counts of open round and square brackets on the stack are kept in registers, so a closing
// bracket with no opener is spotted at once and answered with a status word. The last word
// caused by a token carries tlast; one pending word is held back until it is known whether
// more follow. The output register lets the next token in while the previous result still
// waits.
module infix_to_postfix_converter import ifp_pkg::*; #(
    parameter int STACK_DEPTH = 32,
    parameter int TAG_WIDTH   = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    // slave side
    input  wire logic                                     i_s_axis_tvalid,
    output logic                                          o_s_axis_tready,
    // tdata from bit 0: in_op, in_tag, zero fill
    input  wire logic [((OP_W+TAG_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,
    // tuser: in_kind
    input  wire logic [KIND_W-1:0]                        i_s_axis_tuser,
    // tlast: flush
    input  wire logic                                     i_s_axis_tlast,
    // master side
    output logic                                          o_m_axis_tvalid,
    input  wire logic                                     i_m_axis_tready,
    // tdata from bit 0: out_op, out_tag, zero fill
    output logic      [((OP_W+TAG_WIDTH+7)/8)*8-1:0]      o_m_axis_tdata,
    // tuser from bit 0: out_kind, end_marker, status
    output logic      [KIND_W+STAT_W:0]                   o_m_axis_tuser,
    // tlast: last_in_run
    output logic                                          o_m_axis_tlast
);

    localparam int DW = ((OP_W + TAG_WIDTH + 7) / 8) * 8;
    localparam int EW = KIND_W + OP_W + TAG_WIDTH;     // stack entry: tag, op, kind
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    // sequencer state and stack bookkeeping
    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_paren, n_paren;           // open round brackets on the stack
    logic [CW-1:0] r_square, n_square;         // open square brackets on the stack

    // token under work
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [OP_W-1:0]      r_op, n_op;
    logic [TAG_WIDTH-1:0] r_tag, n_tag;
    logic                 r_flush, n_flush;

    // pending word, held until we know whether it is the last of its run
    logic                 r_pend_valid, n_pend_valid;
    logic [KIND_W-1:0]    r_pend_kind, n_pend_kind;
    logic [OP_W-1:0]      r_pend_op, n_pend_op;
    logic [TAG_WIDTH-1:0] r_pend_tag, n_pend_tag;
    logic                 r_pend_endm, n_pend_endm;
    logic [STAT_W-1:0]    r_pend_stat, n_pend_stat;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [KIND_W-1:0]    r_out_kind, n_out_kind;
    logic [OP_W-1:0]      r_out_op, n_out_op;
    logic [TAG_WIDTH-1:0] r_out_tag, n_out_tag;
    logic                 r_out_last, n_out_last;
    logic                 r_out_endm, n_out_endm;
    logic [STAT_W-1:0]    r_out_stat, n_out_stat;

    // stack ram port
    logic          ram_wr_en, ram_rd_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [EW-1:0] ram_wr_data, ram_rd_data;

    // decoded input word and stack top
    logic [KIND_W-1:0]    in_kind;
    logic [OP_W-1:0]      in_op;
    logic [TAG_WIDTH-1:0] in_tag;
    logic [KIND_W-1:0]    top_kind;
    logic [OP_W-1:0]      top_op;
    logic [TAG_WIDTH-1:0] top_tag;
    logic [CW-1:0]        count_m1;
    logic [KIND_W-1:0]    opener;
    logic [OP_W-1:0]      stored_op;
    logic                 out_free, pend_room, top_pop;

    assign in_kind  = i_s_axis_tuser;
    assign in_op    = i_s_axis_tdata[OP_W-1:0];
    assign in_tag   = i_s_axis_tdata[OP_W+TAG_WIDTH-1:OP_W];
    assign top_kind = ram_rd_data[KIND_W-1:0];
    assign top_op   = ram_rd_data[KIND_W+OP_W-1:KIND_W];
    assign top_tag  = ram_rd_data[EW-1:KIND_W+OP_W];
    assign count_m1 = r_count - ONE;
    assign opener   = (r_kind == K_CLOSE_PAREN) ? K_OPEN_PAREN : K_OPEN_SQUARE;
    // only operators keep their code on the stack
    assign stored_op = (r_kind == K_OPERATOR) ? r_op : OP_NONE;

    // the output register can take a word this cycle
    assign out_free  = !r_out_valid || i_m_axis_tready;
    // the pending slot can take a new word (its old word moves on)
    assign pend_room = !r_pend_valid || out_free;

    // pop rule for the entry on top of the stack
    always_comb begin
        top_pop = 1'b0;
        if (r_flush) begin
            top_pop = 1'b1;
        end else begin
            case (r_kind)
                K_CLOSE_PAREN, K_CLOSE_SQUARE: begin
                    top_pop = (top_kind != opener);
                end
                K_OPERATOR: begin
                    top_pop = ((top_kind == K_OPERATOR) && (f_prio(r_op) <= f_prio(top_op)))
                              || (top_kind == K_FUNCTION) || (top_kind == K_ARRAY);
                end
                K_ARRAY, K_FUNCTION: begin
                    top_pop = (top_kind == r_kind);
                end
                default: begin
                    top_pop = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_paren      <= '0;
            r_square     <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_paren      <= n_paren;
            r_square     <= n_square;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_op        <= n_op;
        r_tag       <= n_tag;
        r_flush     <= n_flush;
        r_pend_kind <= n_pend_kind;
        r_pend_op   <= n_pend_op;
        r_pend_tag  <= n_pend_tag;
        r_pend_endm <= n_pend_endm;
        r_pend_stat <= n_pend_stat;
        r_out_kind  <= n_out_kind;
        r_out_op    <= n_out_op;
        r_out_tag   <= n_out_tag;
        r_out_last  <= n_out_last;
        r_out_endm  <= n_out_endm;
        r_out_stat  <= n_out_stat;
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_paren      = r_paren;
        n_square     = r_square;
        n_kind       = r_kind;
        n_op         = r_op;
        n_tag        = r_tag;
        n_flush      = r_flush;
        n_pend_valid = r_pend_valid;
        n_pend_kind  = r_pend_kind;
        n_pend_op    = r_pend_op;
        n_pend_tag   = r_pend_tag;
        n_pend_endm  = r_pend_endm;
        n_pend_stat  = r_pend_stat;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_op     = r_out_op;
        n_out_tag    = r_out_tag;
        n_out_last   = r_out_last;
        n_out_endm   = r_out_endm;
        n_out_stat   = r_out_stat;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_count[AW-1:0];
        ram_wr_data  = {r_tag, stored_op, r_kind};
        ram_rd_en    = 1'b0;
        ram_rd_addr  = count_m1[AW-1:0];
        // nothing is taken while reset is held
        o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_kind  = in_kind;
                    n_op    = in_op;
                    n_tag   = in_tag;
                    n_flush = i_s_axis_tlast;
                    if (i_s_axis_tlast) begin
                        n_state = S_READ;
                    end else begin
                        case (in_kind)
                            K_OPERAND: begin
                                n_pend_valid = 1'b1;
                                n_pend_kind  = K_OPERAND;
                                n_pend_op    = OP_NONE;
                                n_pend_tag   = in_tag;
                                n_pend_endm  = 1'b0;
                                n_pend_stat  = ST_OK;
                                n_state      = S_DONE;
                            end
                            K_OPEN_PAREN, K_OPEN_SQUARE: begin
                                if (r_count == FULL) begin
                                    n_pend_valid = 1'b1;
                                    n_pend_kind  = in_kind;
                                    n_pend_op    = OP_NONE;
                                    n_pend_tag   = in_tag;
                                    n_pend_endm  = 1'b0;
                                    n_pend_stat  = ST_OVERFLOW;
                                    n_state      = S_DONE;
                                end else begin
                                    // push straight away, nothing to emit
                                    ram_wr_en   = 1'b1;
                                    ram_wr_data = {in_tag, OP_NONE, in_kind};
                                    n_count     = r_count + ONE;
                                    if (in_kind == K_OPEN_PAREN) begin
                                        n_paren = r_paren + ONE;
                                    end else begin
                                        n_square = r_square + ONE;
                                    end
                                end
                            end
                            K_CLOSE_PAREN, K_CLOSE_SQUARE: begin
                                if (((in_kind == K_CLOSE_PAREN) && (r_paren == '0)) ||
                                    ((in_kind == K_CLOSE_SQUARE) && (r_square == '0))) begin
                                    n_pend_valid = 1'b1;
                                    n_pend_kind  = in_kind;
                                    n_pend_op    = OP_NONE;
                                    n_pend_tag   = in_tag;
                                    n_pend_endm  = 1'b0;
                                    n_pend_stat  = ST_NO_OPENER;
                                    n_state      = S_DONE;
                                end else begin
                                    n_state = S_READ;
                                end
                            end
                            default: begin
                                n_state = S_READ;
                            end
                        endcase
                    end
                end
            end

            S_READ: begin
                if (r_count == '0) begin
                    n_state = S_END;
                end else begin
                    ram_rd_en = 1'b1;
                    n_state   = S_EVAL;
                end
            end

            S_EVAL: begin
                if (!r_flush && ((r_kind == K_CLOSE_PAREN) || (r_kind == K_CLOSE_SQUARE))
                    && !top_pop) begin
                    // matching opener on top: drop it and finish
                    n_count = count_m1;
                    if (opener == K_OPEN_PAREN) begin
                        n_paren = r_paren - ONE;
                    end else begin
                        n_square = r_square - ONE;
                    end
                    n_state = r_pend_valid ? S_DONE : S_IDLE;
                end else if (top_pop) begin
                    if (pend_room) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = r_pend_kind;
                            n_out_op    = r_pend_op;
                            n_out_tag   = r_pend_tag;
                            n_out_last  = 1'b0;
                            n_out_endm  = r_pend_endm;
                            n_out_stat  = r_pend_stat;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_kind  = top_kind;
                        n_pend_op    = top_op;
                        n_pend_tag   = top_tag;
                        n_pend_endm  = 1'b0;
                        n_pend_stat  = ST_OK;
                        n_count      = count_m1;
                        if (top_kind == K_OPEN_PAREN) begin
                            n_paren = r_paren - ONE;
                        end
                        if (top_kind == K_OPEN_SQUARE) begin
                            n_square = r_square - ONE;
                        end
                        n_state = S_READ;
                    end
                end else begin
                    n_state = S_END;
                end
            end

            S_END: begin
                if (r_flush || (r_count == FULL)) begin
                    // end marker, or overflow word for a push that found no room
                    if (pend_room) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = r_pend_kind;
                            n_out_op    = r_pend_op;
                            n_out_tag   = r_pend_tag;
                            n_out_last  = 1'b0;
                            n_out_endm  = r_pend_endm;
                            n_out_stat  = r_pend_stat;
                        end
                        n_pend_valid = 1'b1;
                        if (r_flush) begin
                            n_pend_kind = K_OPERAND;
                            n_pend_op   = OP_NONE;
                            n_pend_tag  = '0;
                            n_pend_endm = 1'b1;
                            n_pend_stat = ST_OK;
                        end else begin
                            n_pend_kind = r_kind;
                            n_pend_op   = stored_op;
                            n_pend_tag  = r_tag;
                            n_pend_endm = 1'b0;
                            n_pend_stat = ST_OVERFLOW;
                        end
                        n_state = S_DONE;
                    end
                end else begin
                    // operator, array or function name goes on the stack
                    ram_wr_en = 1'b1;
                    n_count   = r_count + ONE;
                    n_state   = r_pend_valid ? S_DONE : S_IDLE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_pend_kind;
                    n_out_op     = r_pend_op;
                    n_out_tag    = r_pend_tag;
                    n_out_last   = 1'b1;
                    n_out_endm   = r_pend_endm;
                    n_out_stat   = r_pend_stat;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    ifp_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DW'({r_out_tag, r_out_op});
    assign o_m_axis_tuser  = {r_out_stat, r_out_endm, r_out_kind};
    assign o_m_axis_tlast  = r_out_last;

    // stack never holds more than its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("stack count beyond depth");

    // bracket counts cannot exceed the stack fill
    a_bracket_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_paren} + {1'b0, r_square}) <= {1'b0, r_count})
        else $error("bracket counts exceed stack fill");

    // a new token is only taken once the previous run has left the pending slot
    a_ready_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !r_pend_valid)
        else $error("token taken while a word is still pending");

    // the end marker always closes its run
    a_endm_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_endm) |-> r_out_last)
        else $error("end marker without tlast");

endmodule

`default_nettype wire

[tb/tb_infix_to_postfix_converter.sv]
// testbench for the infix to postfix converter: directed table, random expressions, word checks
`default_nettype none

module tb_infix_to_postfix_converter;
    import ifp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH   = 32;
    localparam int TAG_W         = 16;
    localparam int DATA_W        = ((OP_W + TAG_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS  = 370;
    localparam int TAIL_CYCLES   = 100;

    // operator codes the package leaves unnamed
    localparam logic [OP_W-1:0] OP_UNKNOWN  = 4'd11;
    localparam logic [OP_W-1:0] OP_RESERVED = 4'd13;
    localparam logic [OP_W-1:0] OP_TOP_CODE = 4'd15;

    // one word of the postfix stream, as it is predicted and as it is checked
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OP_W-1:0]   op;
        logic [TAG_W-1:0]  tag;
        logic              last;
        logic              endm;
        logic [STAT_W-1:0] status;
    } t_postfix_word;

    // one row of the directed table; word is only used where typed is set
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OP_W-1:0]   op;
        logic [TAG_W-1:0]  tag;
        logic              fl;
        logic              typed;
        t_postfix_word     word;
    } t_token_row;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic [KIND_W-1:0] s_tuser  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tready = 1'b0;

    wire logic                 s_tready;
    wire logic                 m_tvalid;
    wire logic [DATA_W-1:0]    m_tdata;
    wire logic [KIND_W+STAT_W:0] m_tuser;
    wire logic                 m_tlast;

    infix_to_postfix_converter #(
        .STACK_DEPTH (STACK_DEPTH),
        .TAG_WIDTH   (TAG_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // expected words in arrival order, and the words caused by the token being predicted
    t_postfix_word pending_words[$];
    t_postfix_word run_words[$];

    // predictor copy of the operator stack
    logic [KIND_W-1:0] stk_kind [STACK_DEPTH];
    logic [OP_W-1:0]   stk_op   [STACK_DEPTH];
    logic [TAG_W-1:0]  stk_tag  [STACK_DEPTH];
    int                stk_count = 0;

    int err_count       = 0;
    int tokens_sent     = 0;
    int words_checked   = 0;
    int no_opener_words = 0;
    int overflow_words  = 0;
    int longest_run     = 0;
    int burst_left      = 0;

    // random field values at their own widths
    function automatic logic [KIND_W-1:0] rnd_kind();
        return KIND_W'($urandom_range(0, 7));
    endfunction

    function automatic logic [OP_W-1:0] rnd_op();
        return OP_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [TAG_W-1:0] rnd_tag();
        return TAG_W'($urandom_range(0, 16'hffff));
    endfunction

    // binding strength of an operator code; unassigned codes bind weakest
    function automatic int op_rank(input logic [OP_W-1:0] op);
        int r;
        r = 0;
        if (op == OP_AND || op == OP_OR) r = 5;
        if (op == OP_ADD || op == OP_SUB || op == OP_NEG) r = 10;
        if (op == OP_MUL || op == OP_DIV || op == OP_MOD) r = 20;
        if (op == OP_POW || op == OP_FACT) r = 30;
        if (op == OP_NOT) r = 40;
        return r;
    endfunction

    function automatic void emit_word(input logic [KIND_W-1:0] kind, input logic [OP_W-1:0] op,
                                      input logic [TAG_W-1:0] tag, input logic endm,
                                      input logic [STAT_W-1:0] status);
        t_postfix_word w;
        w = '{kind, op, tag, 1'b0, endm, status};
        run_words = {run_words, w};
    endfunction

    // appends one word to the list of expected words
    function automatic void expect_word(input t_postfix_word w);
        pending_words = {pending_words, w};
    endfunction

    function automatic void pop_to_output();
        stk_count = stk_count - 1;
        emit_word(stk_kind[stk_count], stk_op[stk_count], stk_tag[stk_count], 1'b0, ST_OK);
    endfunction

    // a push onto a full stack drops the token and answers with an overflow word
    function automatic void push_token(input logic [KIND_W-1:0] kind,
                                       input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag);
        if (stk_count >= STACK_DEPTH) begin
            emit_word(kind, op, tag, 1'b0, ST_OVERFLOW);
            overflow_words++;
        end else begin
            stk_kind[stk_count] = kind;
            stk_op[stk_count]   = op;
            stk_tag[stk_count]  = tag;
            stk_count = stk_count + 1;
        end
    endfunction

    // works out the postfix words one token causes, leaving them in run_words
    function automatic void predict_postfix(input logic [KIND_W-1:0] kind,
                                            input logic [OP_W-1:0] op,
                                            input logic [TAG_W-1:0] tag, input logic fl);
        logic [KIND_W-1:0] opener;
        logic              popping;
        int                found_at;
        int                idx;
        int                top;
        t_postfix_word     w;
        run_words.delete();
        if (fl) begin
            while (stk_count > 0) pop_to_output();
            emit_word(K_OPERAND, OP_NONE, '0, 1'b1, ST_OK);
        end else begin
            case (kind)
                K_OPERAND: begin
                    emit_word(K_OPERAND, OP_NONE, tag, 1'b0, ST_OK);
                end
                K_OPEN_PAREN, K_OPEN_SQUARE: begin
                    push_token(kind, OP_NONE, tag);
                end
                K_CLOSE_PAREN, K_CLOSE_SQUARE: begin
                    opener = (kind == K_CLOSE_PAREN) ? K_OPEN_PAREN : K_OPEN_SQUARE;
                    found_at = -1;
                    for (idx = stk_count - 1; idx >= 0; idx--) begin
                        if (found_at < 0 && stk_kind[idx] == opener) found_at = idx;
                    end
                    if (found_at < 0) begin
                        emit_word(kind, OP_NONE, tag, 1'b0, ST_NO_OPENER);
                        no_opener_words++;
                    end else begin
                        // an opener of the other shape above ours goes out like any token
                        while (stk_count - 1 > found_at) pop_to_output();
                        stk_count = stk_count - 1;
                    end
                end
                K_OPERATOR: begin
                    popping = 1'b1;
                    while (popping && stk_count > 0) begin
                        top = stk_count - 1;
                        if ((stk_kind[top] == K_OPERATOR && op_rank(op) <= op_rank(stk_op[top]))
                            || stk_kind[top] == K_FUNCTION || stk_kind[top] == K_ARRAY) begin
                            pop_to_output();
                        end else begin
                            popping = 1'b0;
                        end
                    end
                    push_token(K_OPERATOR, op, tag);
                end
                default: begin
                    // array and function names only displace their own kind
                    while (stk_count > 0 && stk_kind[stk_count - 1] == kind) pop_to_output();
                    push_token(kind, OP_NONE, tag);
                end
            endcase
        end
        for (idx = 0; idx < run_words.size(); idx++) begin
            w = run_words[idx];
            w.last = (idx == run_words.size() - 1);
            run_words[idx] = w;
        end
        if (run_words.size() > longest_run) longest_run = run_words.size();
    endfunction

    // offers one token word on the slave side, with bursts and gaps, until it is taken
    task automatic send_token(input logic [KIND_W-1:0] kind, input logic [OP_W-1:0] op,
                              input logic [TAG_W-1:0] tag, input logic fl,
                              input logic typed, input t_postfix_word typed_word);
        int gap;
        int idx;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        predict_postfix(kind, op, tag, fl);
        if (typed) begin
            expect_word(typed_word);
        end else begin
            for (idx = 0; idx < run_words.size(); idx++) expect_word(run_words[idx]);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(DATA_W - OP_W - TAG_W){1'b0}}, tag, op};
        s_tuser  <= kind;
        s_tlast  <= fl;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        tokens_sent++;
    endtask

    // receiver: always ready, coin toss, mostly ready, or long stalls, changing now and then
    int rx_mode       = 0;
    int rx_phase_left = 0;
    int rx_stall_left = 0;

    always @(posedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_mode       = $urandom_range(0, 3);
            rx_phase_left = $urandom_range(20, 80);
        end else begin
            rx_phase_left--;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 7) != 0);
            default: begin
                if (rx_stall_left != 0) begin
                    rx_stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    if ($urandom_range(0, 5) == 0) rx_stall_left = $urandom_range(3, 12);
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    function automatic void compare_field(input string name, input logic [TAG_W-1:0] want,
                                          input logic [TAG_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // every accepted word is checked against the oldest prediction
    always @(posedge i_clk) begin
        t_postfix_word want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t ns: unexpected word, expected none, actual tdata 0x%0h tuser 0x%0h",
                         $time, m_tdata, m_tuser);
                err_count++;
            end else begin
                want = pending_words.pop_front();
                compare_field("kind", TAG_W'(want.kind), TAG_W'(m_tuser[KIND_W-1:0]));
                compare_field("op", TAG_W'(want.op), TAG_W'(m_tdata[OP_W-1:0]));
                compare_field("tag", want.tag, m_tdata[OP_W +: TAG_W]);
                compare_field("last_in_run", TAG_W'(want.last), TAG_W'(m_tlast));
                compare_field("end_marker", TAG_W'(want.endm), TAG_W'(m_tuser[KIND_W]));
                compare_field("status", TAG_W'(want.status), TAG_W'(m_tuser[KIND_W+1 +: STAT_W]));
                words_checked++;
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("[infix_to_postfix_converter] ERROR");
        $finish;
    end

    t_token_row            directed_rows[$];
    logic [KIND_W-1:0]     open_shapes[$];
    logic [KIND_W-1:0]     shape;
    t_token_row            row;
    int                    idx;
    int                    pick;
    int                    n_tok;
    int                    n_directed;
    logic                  want_operand;

    // appends one row to the directed table
    function automatic void add_row(input t_token_row r);
        directed_rows = {directed_rows, r};
    endfunction

    initial begin
        // reset state and plain extremes: expected words typed in
        add_row(t_token_row'{K_CLOSE_PAREN, OP_NONE, 16'h1234, 1'b0, 1'b1,
                             '{K_CLOSE_PAREN, OP_NONE, 16'h1234, 1'b1, 1'b0, ST_NO_OPENER}});
        add_row(t_token_row'{K_CLOSE_SQUARE, OP_TOP_CODE, 16'hffff, 1'b0, 1'b1,
                             '{K_CLOSE_SQUARE, OP_NONE, 16'hffff, 1'b1, 1'b0, ST_NO_OPENER}});
        add_row(t_token_row'{K_OPERAND, OP_NONE, 16'h0000, 1'b0, 1'b1,
                             '{K_OPERAND, OP_NONE, 16'h0000, 1'b1, 1'b0, ST_OK}});
        add_row(t_token_row'{K_OPERAND, OP_TOP_CODE, 16'hffff, 1'b0, 1'b1,
                             '{K_OPERAND, OP_NONE, 16'hffff, 1'b1, 1'b0, ST_OK}});
        add_row(t_token_row'{K_FUNCTION, OP_TOP_CODE, 16'hffff, 1'b1, 1'b1,
                             '{K_OPERAND, OP_NONE, 16'h0000, 1'b1, 1'b1, ST_OK}});
        // f(a + b) * g[(c ^] then more operators: mixed shapes, add, multiply and power classes, unnamed codes
        add_row(t_token_row'{K_FUNCTION, OP_NONE, 16'h0101, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPEN_PAREN, OP_NONE, 16'h0202, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERAND, OP_NONE, 16'h0a0a, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERATOR, OP_ADD, 16'h0303, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERAND, OP_NONE, 16'h0b0b, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_CLOSE_PAREN, OP_NONE, 16'h0404, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERATOR, OP_MUL, 16'h0505, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_ARRAY, OP_NONE, 16'h0606, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPEN_SQUARE, OP_NONE, 16'h0707, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPEN_PAREN, OP_NONE, 16'h0808, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERAND, OP_NONE, 16'h0c0c, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERATOR, OP_POW, 16'h0909, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_CLOSE_SQUARE, OP_NONE, 16'h1010, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERATOR, OP_NEG, 16'h1111, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERATOR, OP_FACT, 16'h1212, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERATOR, OP_DIV, 16'h1313, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERATOR, OP_UNKNOWN, 16'h1414, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERATOR, OP_RESERVED, 16'h1515, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPERAND, OP_NONE, 16'h8000, 1'b0, 1'b0, '0});
        add_row(t_token_row'{K_OPEN_SQUARE, OP_NONE, 16'h0000, 1'b1, 1'b0, '0});
        n_directed = directed_rows.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[idx]) begin
            row = directed_rows[idx];
            send_token(row.kind, row.op, row.tag, row.fl, row.typed, row.word);
        end

        // hold the sender until the stream has drained completely
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);

        while (tokens_sent < n_directed + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                // push brackets until the stack is near or past full, unwind part of it, then flush
                n_tok = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
                for (idx = 0; idx < n_tok; idx++) begin
                    if ($urandom_range(0, 7) == 0) begin
                        send_token(K_OPERAND, rnd_op(), rnd_tag(), 1'b0, 1'b0, '0);
                    end else begin
                        shape = ($urandom_range(0, 1) == 1) ? K_OPEN_PAREN : K_OPEN_SQUARE;
                        send_token(shape, rnd_op(), rnd_tag(), 1'b0, 1'b0, '0);
                    end
                end
                n_tok = $urandom_range(0, 4);
                for (idx = 0; idx < n_tok; idx++) begin
                    shape = ($urandom_range(0, 1) == 1) ? K_CLOSE_PAREN : K_CLOSE_SQUARE;
                    send_token(shape, OP_NONE, rnd_tag(), 1'b0, 1'b0, '0);
                end
                send_token(rnd_kind(), rnd_op(), rnd_tag(), 1'b1, 1'b0, '0);
            end else if (pick < 4) begin
                // noise: any kind, any code, stray flushes
                n_tok = $urandom_range(1, 6);
                for (idx = 0; idx < n_tok; idx++) begin
                    send_token(rnd_kind(), rnd_op(), rnd_tag(), ($urandom_range(0, 7) == 0),
                               1'b0, '0);
                end
            end else begin
                // mostly well-formed expression, tracking which brackets are open
                open_shapes.delete();
                want_operand = 1'b1;
                n_tok = $urandom_range(2, 14);
                for (idx = 0; idx < n_tok; idx++) begin
                    pick = $urandom_range(0, 9);
                    if (want_operand) begin
                        if (pick < 6) begin
                            send_token(K_OPERAND, OP_NONE, rnd_tag(), 1'b0, 1'b0, '0);
                            want_operand = 1'b0;
                        end else if (pick < 8) begin
                            shape = ($urandom_range(0, 1) == 1) ? K_OPEN_PAREN : K_OPEN_SQUARE;
                            send_token(shape, OP_NONE, rnd_tag(), 1'b0, 1'b0, '0);
                            open_shapes = {open_shapes, shape};
                        end else if (pick < 9) begin
                            // function call or array index: name, then its opener
                            if ($urandom_range(0, 1) == 1) begin
                                send_token(K_FUNCTION, OP_NONE, rnd_tag(), 1'b0, 1'b0, '0);
                                shape = K_OPEN_PAREN;
                            end else begin
                                send_token(K_ARRAY, OP_NONE, rnd_tag(), 1'b0, 1'b0, '0);
                                shape = K_OPEN_SQUARE;
                            end
                            send_token(shape, OP_NONE, rnd_tag(), 1'b0, 1'b0, '0);
                            open_shapes = {open_shapes, shape};
                        end else begin
                            send_token(K_OPERATOR, ($urandom_range(0, 1) == 1) ? OP_NEG : OP_NOT,
                                       rnd_tag(), 1'b0, 1'b0, '0);
                        end
                    end else begin
                        if (pick < 6) begin
                            send_token(K_OPERATOR, rnd_op(), rnd_tag(), 1'b0, 1'b0, '0);
                            want_operand = 1'b1;
                        end else if (pick < 8 && open_shapes.size() != 0) begin
                            shape = open_shapes.pop_back();
                            send_token((shape == K_OPEN_PAREN) ? K_CLOSE_PAREN : K_CLOSE_SQUARE,
                                       OP_NONE, rnd_tag(), 1'b0, 1'b0, '0);
                        end else if (pick < 9) begin
                            send_token(K_OPERATOR, OP_FACT, rnd_tag(), 1'b0, 1'b0, '0);
                        end else begin
                            // broken: a close of either shape whatever is open
                            shape = ($urandom_range(0, 1) == 1) ? K_CLOSE_PAREN : K_CLOSE_SQUARE;
                            send_token(shape, OP_NONE, rnd_tag(), 1'b0, 1'b0, '0);
                        end
                    end
                end
                while (open_shapes.size() != 0 && $urandom_range(0, 7) != 0) begin
                    shape = open_shapes.pop_back();
                    send_token((shape == K_OPEN_PAREN) ? K_CLOSE_PAREN : K_CLOSE_SQUARE,
                               OP_NONE, rnd_tag(), 1'b0, 1'b0, '0);
                end
                send_token(rnd_kind(), rnd_op(), rnd_tag(), 1'b1, 1'b0, '0);
            end
            if ($urandom_range(0, 9) == 0) begin
                s_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending_words.size() != 0) @(posedge i_clk);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d tokens (%0d from the table), %0d postfix words checked, %0s %0d",
                 tokens_sent, n_directed, words_checked, "longest run", longest_run);
        $display("status words: %0d closes without opener, %0d stack overflows",
                 no_opener_words, overflow_words);
        if (err_count == 0) begin
            $display("[infix_to_postfix_converter] OK");
        end else begin
            $display("[infix_to_postfix_converter] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
src/ifp_pkg.sv
src/ifp_ram.sv
src/infix_to_postfix_converter.sv
tb/tb_infix_to_postfix_converter.sv
